>>> hdl/foveated_shading_rate_map_assert.svh
// ----------------------------------------------------------------------------
// Foveated shading-rate map assertion macros
// Shared concurrent assertion forms used by the shading-rate map top level.
// ----------------------------------------------------------------------------
`ifndef FOVEATED_SHADING_RATE_MAP_ASSERT_SVH
`define FOVEATED_SHADING_RATE_MAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSRM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fsrm_pkg.sv
// ----------------------------------------------------------------------------
// Foveated shading-rate map package
// Shared widths, register indexes, rate codes and control structures.
// ----------------------------------------------------------------------------
package fsrm_pkg;

  localparam int NSTAGE     = 5;
  localparam int SCENE_W    = 15;
  localparam int GAZE_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int RAD_W      = 16;
  localparam int TILE_IDX_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RATE_W     = 2;
  // Product of scene width and (1 + 16-bit gaze u), and of height and gaze v.
  localparam int BX_W       = SCENE_W + FRAC_W + 1;
  localparam int CY_W       = SCENE_W + FRAC_W;
  localparam int SQ_SCENE_W = 2 * SCENE_W;
  // w^2 + 4 h^2 fits in one bit more than 4 h^2.
  localparam int K_W        = 2 * SCENE_W + 3;
  localparam int R2_W       = 2 * RAD_W;
  // Threshold keeps the factor of 16 as a shift.
  localparam int THR_W      = R2_W + K_W + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_W         = 3'd0,
    REG_TARGET_H         = 3'd1,
    REG_TWO_EYE          = 3'd2,
    REG_COARSEST_ALLOWED = 3'd3,
    REG_GAZE_LEFT        = 3'd4,
    REG_GAZE_RIGHT       = 3'd5,
    REG_INNER_RADIUS     = 3'd6,
    REG_OUTER_RADIUS     = 3'd7
  } cfg_reg_e;

  typedef enum logic [RATE_W-1:0] {
    RATE_1X1 = 2'd0,
    RATE_2X2 = 2'd1,
    RATE_4X4 = 2'd2
  } rate_e;

  typedef struct packed {
    logic [SCENE_W-1:0] target_w;
    logic [SCENE_W-1:0] target_h;
    logic               two_eye;
    logic               coarsest_allowed;
    logic [GAZE_W-1:0]  gaze_left;
    logic [GAZE_W-1:0]  gaze_right;
    logic [RAD_W-1:0]   inner_radius;
    logic [RAD_W-1:0]   outer_radius;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    target_w:         15'd2048,
    target_h:         15'd2048,
    two_eye:          1'b0,
    coarsest_allowed: 1'b0,
    gaze_left:        32'h8000_8000,
    gaze_right:       32'h8000_8000,
    inner_radius:     16'd6554,
    outer_radius:     16'd13107
  };

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld;
  } pipe_ctrl_t;

endpackage

>>> hdl/fsrm_cfg.sv
// ----------------------------------------------------------------------------
// Foveated shading-rate map configuration registers
// Holds the eight configuration registers written through the write port.
// ----------------------------------------------------------------------------
module fsrm_cfg import fsrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_TARGET_W:         cfg_regs.target_w         <= cfg_wdata[SCENE_W-1:0];
        REG_TARGET_H:         cfg_regs.target_h         <= cfg_wdata[SCENE_W-1:0];
        REG_TWO_EYE:          cfg_regs.two_eye          <= cfg_wdata[0];
        REG_COARSEST_ALLOWED: cfg_regs.coarsest_allowed <= cfg_wdata[0];
        REG_GAZE_LEFT:        cfg_regs.gaze_left        <= cfg_wdata[GAZE_W-1:0];
        REG_GAZE_RIGHT:       cfg_regs.gaze_right       <= cfg_wdata[GAZE_W-1:0];
        REG_INNER_RADIUS:     cfg_regs.inner_radius     <= cfg_wdata[RAD_W-1:0];
        REG_OUTER_RADIUS:     cfg_regs.outer_radius     <= cfg_wdata[RAD_W-1:0];
      endcase
    end
  end

  assign cfg = cfg_regs;

endmodule

>>> hdl/fsrm_ctrl.sv
// ----------------------------------------------------------------------------
// Foveated shading-rate map pipeline control
// Valid bits per stage and a ready chain that lets bubbles collapse.
// ----------------------------------------------------------------------------
module fsrm_ctrl import fsrm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_ready,
  output logic       in_ready,
  output pipe_ctrl_t ctrl
);

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // A stage may load when it is empty or when its content moves on.
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign ctrl.en  = en;
  assign ctrl.vld = vld;

endmodule

>>> hdl/fsrm_dist.sv
// ----------------------------------------------------------------------------
// Foveated shading-rate map distance stages
// Stages one and two: tile centre, eye choice, scaled axis distances and the
// radius and diagonal terms of the thresholds.
// ----------------------------------------------------------------------------
module fsrm_dist import fsrm_pkg::*; #(
  parameter int TILE      = 16,
  parameter int MAX_SCENE = 16384,
  parameter int PCX_W     = 16,
  parameter int DX_W      = 33,
  parameter int DY_W      = 32
) (
  input  logic                  clk,
  input  pipe_ctrl_t            ctrl,
  input  cfg_t                  cfg,
  input  logic [TILE_IDX_W-1:0] tile_col,
  input  logic [TILE_IDX_W-1:0] tile_row,
  output logic [DX_W-1:0]       dx,
  output logic [DY_W:0]         dyn,
  output logic [K_W-1:0]        k,
  output logic [R2_W-1:0]       ri2,
  output logic [R2_W-1:0]       ro2
);

  // Stage one logic.
  logic [SCENE_W-1:0] w_sat;
  logic [SCENE_W-1:0] h_sat;
  logic [PCX_W-1:0]   pcx;
  logic [PCX_W-1:0]   pcy;
  logic               eye;
  logic [GAZE_W-1:0]  gaze;

  // Stage one registers.
  logic [PCX_W:0]        st1_ax;
  logic [PCX_W-1:0]      st1_pcy;
  logic [BX_W-1:0]       st1_bx;
  logic [CY_W-1:0]       st1_cy;
  logic [SQ_SCENE_W-1:0] st1_ww;
  logic [SQ_SCENE_W-1:0] st1_hh;
  logic [R2_W-1:0]       st1_ri2;
  logic [R2_W-1:0]       st1_ro2;
  logic                  st1_dw;

  // Stage two logic.
  logic [DX_W-1:0] xa;
  logic [DX_W-1:0] xb;
  logic [DY_W-1:0] ya;
  logic [DY_W-1:0] yb;
  logic [DY_W-1:0] dy;

  always_comb begin
    w_sat = (int'(cfg.target_w) > MAX_SCENE) ? SCENE_W'(MAX_SCENE) : cfg.target_w;
    h_sat = (int'(cfg.target_h) > MAX_SCENE) ? SCENE_W'(MAX_SCENE) : cfg.target_h;
    // Twice the tile centre, so the half-tile offset stays an integer.
    pcx   = PCX_W'((2 * int'(tile_col) + 1) * TILE);
    pcy   = PCX_W'((2 * int'(tile_row) + 1) * TILE);
    eye   = cfg.two_eye && (int'(pcx) >= int'(w_sat));
    gaze  = eye ? cfg.gaze_right : cfg.gaze_left;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      st1_ax  <= cfg.two_eye ? {pcx, 1'b0} : {1'b0, pcx};
      st1_pcy <= pcy;
      st1_bx  <= BX_W'(w_sat) * BX_W'({eye, gaze[GAZE_W-1:FRAC_W]});
      st1_cy  <= CY_W'(h_sat) * CY_W'(gaze[FRAC_W-1:0]);
      st1_ww  <= SQ_SCENE_W'(w_sat) * SQ_SCENE_W'(w_sat);
      st1_hh  <= SQ_SCENE_W'(h_sat) * SQ_SCENE_W'(h_sat);
      st1_ri2 <= R2_W'(cfg.inner_radius) * R2_W'(cfg.inner_radius);
      st1_ro2 <= R2_W'(cfg.outer_radius) * R2_W'(cfg.outer_radius);
      st1_dw  <= cfg.two_eye;
    end
  end

  always_comb begin
    xa = DX_W'({st1_ax, {FRAC_W{1'b0}}});
    xb = DX_W'({st1_bx, 1'b0});
    ya = DY_W'({st1_pcy, {FRAC_W{1'b0}}});
    yb = DY_W'({st1_cy, 1'b0});
    dy = (ya >= yb) ? (ya - yb) : (yb - ya);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      dx  <= (xa >= xb) ? (xa - xb) : (xb - xa);
      dyn <= st1_dw ? {dy, 1'b0} : {1'b0, dy};
      k   <= K_W'(st1_ww) + (st1_dw ? K_W'({st1_hh, 2'b00}) : K_W'(st1_hh));
      ri2 <= st1_ri2;
      ro2 <= st1_ro2;
    end
  end

endmodule

>>> hdl/fsrm_sq.sv
// ----------------------------------------------------------------------------
// Foveated shading-rate map squaring stages
// Stages three and four: squares of the axis distances from split partial
// products, and the two ring thresholds.
// ----------------------------------------------------------------------------
module fsrm_sq import fsrm_pkg::*; #(
  parameter int DX_W  = 33,
  parameter int DYN_W = 33
) (
  input  logic               clk,
  input  pipe_ctrl_t         ctrl,
  input  logic [DX_W-1:0]    dx,
  input  logic [DYN_W-1:0]   dyn,
  input  logic [K_W-1:0]     k,
  input  logic [R2_W-1:0]    ri2,
  input  logic [R2_W-1:0]    ro2,
  output logic [2*DX_W-1:0]  dx2,
  output logic [2*DYN_W-1:0] dy2,
  output logic [THR_W-1:0]   thr_in,
  output logic [THR_W-1:0]   thr_out
);

  localparam int XL = (DX_W + 1) / 2;
  localparam int XH = DX_W - XL;
  localparam int YL = (DYN_W + 1) / 2;
  localparam int YH = DYN_W - YL;
  localparam int PT_W = R2_W + K_W;

  logic [2*XH-1:0]  x_hh;
  logic [DX_W-1:0]  x_hl;
  logic [2*XL-1:0]  x_ll;
  logic [2*YH-1:0]  y_hh;
  logic [DYN_W-1:0] y_hl;
  logic [2*YL-1:0]  y_ll;
  logic [PT_W-1:0]  pt_in;
  logic [PT_W-1:0]  pt_out;

  // x^2 = xh^2 * 2^(2L) + xh*xl * 2^(L+1) + xl^2
  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      x_hh   <= (2*XH)'(dx[DX_W-1:XL]) * (2*XH)'(dx[DX_W-1:XL]);
      x_hl   <= DX_W'(dx[DX_W-1:XL]) * DX_W'(dx[XL-1:0]);
      x_ll   <= (2*XL)'(dx[XL-1:0]) * (2*XL)'(dx[XL-1:0]);
      y_hh   <= (2*YH)'(dyn[DYN_W-1:YL]) * (2*YH)'(dyn[DYN_W-1:YL]);
      y_hl   <= DYN_W'(dyn[DYN_W-1:YL]) * DYN_W'(dyn[YL-1:0]);
      y_ll   <= (2*YL)'(dyn[YL-1:0]) * (2*YL)'(dyn[YL-1:0]);
      pt_in  <= PT_W'(ri2) * PT_W'(k);
      pt_out <= PT_W'(ro2) * PT_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      dx2     <= ((2*DX_W)'(x_hh) << (2*XL)) + ((2*DX_W)'(x_hl) << (XL + 1))
                 + (2*DX_W)'(x_ll);
      dy2     <= ((2*DYN_W)'(y_hh) << (2*YL)) + ((2*DYN_W)'(y_hl) << (YL + 1))
                 + (2*DYN_W)'(y_ll);
      thr_in  <= {pt_in, 4'b0000};
      thr_out <= {pt_out, 4'b0000};
    end
  end

endmodule

>>> hdl/fsrm_rate.sv
// ----------------------------------------------------------------------------
// Foveated shading-rate map rate stage
// Stage five: sums the squared distances and picks the ring's rate code.
// ----------------------------------------------------------------------------
module fsrm_rate import fsrm_pkg::*; #(
  parameter int DX2_W = 66,
  parameter int DY2_W = 66
) (
  input  logic              clk,
  input  pipe_ctrl_t        ctrl,
  input  logic              coarsest_allowed,
  input  logic [DX2_W-1:0]  dx2,
  input  logic [DY2_W-1:0]  dy2,
  input  logic [THR_W-1:0]  thr_in,
  input  logic [THR_W-1:0]  thr_out,
  output logic [RATE_W-1:0] rate_code
);

  localparam int SUM_W = ((DX2_W > DY2_W) ? DX2_W : DY2_W) + 1;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  logic [CMP_W-1:0] lhs;
  rate_e            rate;

  // Strict compares: a distance exactly on a cutoff keeps the finer rate.
  always_comb begin
    lhs = CMP_W'(dx2) + CMP_W'(dy2);
    if (lhs > CMP_W'(thr_out)) begin
      rate = coarsest_allowed ? RATE_4X4 : RATE_2X2;
    end else if (lhs > CMP_W'(thr_in)) begin
      rate = RATE_2X2;
    end else begin
      rate = RATE_1X1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      rate_code <= rate;
    end
  end

endmodule

>>> hdl/foveated_shading_rate_map.sv
// ----------------------------------------------------------------------------
// Foveated shading-rate map
// Gives the shading rate of one tile of a foveated shading-rate image.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel (in_valid/in_ready) carries one
// tile coordinate, tile_col and tile_row. Each produces exactly one transfer
// on the output channel (out_valid/out_ready) with its rate_code, in order.
// out_valid rises once the tile has passed the pipeline, since the fifth stage
// is the output register, and the block takes one tile every cycle while the
// output is drained. The rate is set by
// the five-stage pipeline: geometry, distance, split multiplies, square
// sums, and the final add and compare against both ring thresholds.
// When the receiver stalls, the held result stays on the output and each
// stage keeps loading as long as one further down is empty, so bubbles are
// squeezed out; in_ready drops only once all five stages hold a tile.
// The configuration port writes one register per cycle with cfg_we; the user
// must have writes made only while no tile is in flight; the block does not
// enforce it. Synchronous reset empties the pipeline and returns all
// registers to their defaults: a 2048 by 2048 mono scene, gaze at the centre,
// inner and outer cutoffs of 0.4 and 0.8 of the half diagonal, outer ring 2x2.
// ----------------------------------------------------------------------------
module foveated_shading_rate_map import fsrm_pkg::*; #(
  parameter int TILE      = 16,
  parameter int MAX_SCENE = 16384
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TILE_IDX_W-1:0] tile_col,
  input  logic [TILE_IDX_W-1:0] tile_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RATE_W-1:0]     rate_code
);

`include "foveated_shading_rate_map_assert.svh"

  // Bits to hold twice the largest tile centre, in pixels.
  localparam int PCX_W = $clog2(((1 << TILE_IDX_W) * 2 - 1) * TILE + 1);
  // Horizontal distance is scaled by 2 * eyes * 65536, vertical by 2 * 65536.
  localparam int DX_W  = ((PCX_W + FRAC_W + 1) > (BX_W + 1)) ?
                         (PCX_W + FRAC_W + 1) : (BX_W + 1);
  localparam int DY_W  = ((PCX_W + FRAC_W) > (CY_W + 1)) ?
                         (PCX_W + FRAC_W) : (CY_W + 1);
  localparam int DYN_W = DY_W + 1;

  cfg_t       cfg;
  pipe_ctrl_t pipe;

  logic [DX_W-1:0]      dx;
  logic [DYN_W-1:0]     dyn;
  logic [K_W-1:0]       k;
  logic [R2_W-1:0]      ri2;
  logic [R2_W-1:0]      ro2;
  logic [2*DX_W-1:0]    dx2;
  logic [2*DYN_W-1:0]   dy2;
  logic [THR_W-1:0]     thr_in;
  logic [THR_W-1:0]     thr_out;

  fsrm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fsrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (pipe)
  );

  // Stages one and two: which eye, and how far the tile centre lies from it.
  fsrm_dist #(
    .TILE      (TILE),
    .MAX_SCENE (MAX_SCENE),
    .PCX_W     (PCX_W),
    .DX_W      (DX_W),
    .DY_W      (DY_W)
  ) u_dist (
    .clk      (clk),
    .ctrl     (pipe),
    .cfg      (cfg),
    .tile_col (tile_col),
    .tile_row (tile_row),
    .dx       (dx),
    .dyn      (dyn),
    .k        (k),
    .ri2      (ri2),
    .ro2      (ro2)
  );

  // Stages three and four: squared distances and the two thresholds.
  fsrm_sq #(
    .DX_W  (DX_W),
    .DYN_W (DYN_W)
  ) u_sq (
    .clk     (clk),
    .ctrl    (pipe),
    .dx      (dx),
    .dyn     (dyn),
    .k       (k),
    .ri2     (ri2),
    .ro2     (ro2),
    .dx2     (dx2),
    .dy2     (dy2),
    .thr_in  (thr_in),
    .thr_out (thr_out)
  );

  // Stage five doubles as the output register.
  fsrm_rate #(
    .DX2_W (2 * DX_W),
    .DY2_W (2 * DYN_W)
  ) u_rate (
    .clk              (clk),
    .ctrl             (pipe),
    .coarsest_allowed (cfg.coarsest_allowed),
    .dx2              (dx2),
    .dy2              (dy2),
    .thr_in           (thr_in),
    .thr_out          (thr_out),
    .rate_code        (rate_code)
  );

  assign out_valid = pipe.vld[NSTAGE-1];

  // An accepted tile always lands in the first stage.
  `FSRM_ASSERT_NEXT(a_accept_fills_first, clk, rst, in_valid && in_ready, pipe.vld[0], "accepted tile lost at stage one")
  // With the output stage empty, nothing may hold off the input.
  `FSRM_ASSERT_SAME(a_ready_when_drained, clk, rst, !out_valid, in_ready, "input blocked with output stage empty")
  // The coarsest rate only appears when it is allowed.
  `FSRM_ASSERT_SAME(a_coarse_allowed, clk, rst, out_valid && (rate_code == RATE_4X4), cfg.coarsest_allowed, "4x4 rate given while not allowed")

endmodule

>>> tb/sv/fsrm_rate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shading-rate map checker
// Watches the configuration port and both channels of the shading-rate map,
// predicts the rate of every tile transfer and compares the results in order.
// ----------------------------------------------------------------------------
module fsrm_rate_checker import fsrm_pkg::*; #(
  parameter int TILE      = 16,
  parameter int MAX_SCENE = 16384
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [TILE_IDX_W-1:0] tile_col,
  input  logic [TILE_IDX_W-1:0] tile_row,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [RATE_W-1:0]     rate_code,
  output int                    mismatch_count,
  output int                    pending_rates
);

  typedef struct packed {
    logic [TILE_IDX_W-1:0] col;
    logic [TILE_IDX_W-1:0] row;
    rate_e                 rate;
  } tile_rate_t;

  tile_rate_t expected_rates[$];
  cfg_t       shadow_cfg = CFG_RESET;

  // Exact integer form of the ring test: both sides are scaled so that no
  // division is needed, and 128 bits hold every product without overflow.
  function automatic rate_e tile_rate(input cfg_t c, input logic [TILE_IDX_W-1:0] col,
                                      input logic [TILE_IDX_W-1:0] row);
    logic [127:0] tx, ty, w, h, ne, pcx, pcy, eye, u, v;
    logic [127:0] xa, xb, ya, yb, dx, dy, dist2, k, thr_inner, thr_outer;
    tx  = 128'(col);
    ty  = 128'(row);
    w   = (int'(c.target_w) > MAX_SCENE) ? 128'(MAX_SCENE) : 128'(c.target_w);
    h   = (int'(c.target_h) > MAX_SCENE) ? 128'(MAX_SCENE) : 128'(c.target_h);
    ne  = c.two_eye ? 128'd2 : 128'd1;
    pcx = (128'd2 * tx + 128'd1) * 128'(TILE);
    pcy = (128'd2 * ty + 128'd1) * 128'(TILE);
    eye = (c.two_eye && pcx >= w) ? 128'd1 : 128'd0;
    u   = 128'(eye[0] ? c.gaze_right[31:16] : c.gaze_left[31:16]);
    v   = 128'(eye[0] ? c.gaze_right[15:0] : c.gaze_left[15:0]);
    xa  = pcx * ne * 128'd65536;
    xb  = 128'd2 * w * ((eye << 16) + u);
    ya  = pcy * 128'd65536;
    yb  = 128'd2 * h * v;
    dx  = (xa >= xb) ? xa - xb : xb - xa;
    dy  = (ya >= yb) ? ya - yb : yb - ya;
    dist2     = dx * dx + (dy * ne) * (dy * ne);
    k         = (w * w + ne * ne * h * h) * 128'd16;
    thr_inner = 128'(c.inner_radius) * 128'(c.inner_radius) * k;
    thr_outer = 128'(c.outer_radius) * 128'(c.outer_radius) * k;
    if (dist2 > thr_outer)
      tile_rate = c.coarsest_allowed ? RATE_4X4 : RATE_2X2;
    else if (dist2 > thr_inner)
      tile_rate = RATE_2X2;
    else
      tile_rate = RATE_1X1;
  endfunction

  task automatic flag(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    tile_rate_t head;
    tile_rate_t fresh;
    if (rst) begin
      shadow_cfg = CFG_RESET;
      expected_rates.delete();
    end else begin
      // Results leave before new tiles are queued, so an unexpected result
      // can never be matched against a tile accepted on the same edge.
      if (out_valid && out_ready) begin
        if (expected_rates.size() == 0) begin
          flag($sformatf("rate_code %0d with no tile outstanding", rate_code));
        end else begin
          head = expected_rates.pop_front();
          if (rate_code !== head.rate)
            flag($sformatf("tile (%0d,%0d): expected rate_code %0d, got %0d",
                           head.col, head.row, head.rate, rate_code));
        end
      end
      if (in_valid && in_ready) begin
        fresh.col  = tile_col;
        fresh.row  = tile_row;
        fresh.rate = tile_rate(shadow_cfg, tile_col, tile_row);
        expected_rates.push_back(fresh);
      end
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          REG_TARGET_W:         shadow_cfg.target_w         = cfg_wdata[SCENE_W-1:0];
          REG_TARGET_H:         shadow_cfg.target_h         = cfg_wdata[SCENE_W-1:0];
          REG_TWO_EYE:          shadow_cfg.two_eye          = cfg_wdata[0];
          REG_COARSEST_ALLOWED: shadow_cfg.coarsest_allowed = cfg_wdata[0];
          REG_GAZE_LEFT:        shadow_cfg.gaze_left        = cfg_wdata[GAZE_W-1:0];
          REG_GAZE_RIGHT:       shadow_cfg.gaze_right       = cfg_wdata[GAZE_W-1:0];
          REG_INNER_RADIUS:     shadow_cfg.inner_radius     = cfg_wdata[RAD_W-1:0];
          REG_OUTER_RADIUS:     shadow_cfg.outer_radius     = cfg_wdata[RAD_W-1:0];
          default: ;
        endcase
      end
    end
    pending_rates = expected_rates.size();
  end

endmodule

>>> tb/sv/tb_foveated_shading_rate_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shading-rate map testbench
// Drives tile coordinates through the shading-rate map under a series of
// register settings, with random bursts on the input and random stalls on the
// output; a checker beside the block predicts and compares every rate.
// ----------------------------------------------------------------------------
module tb_foveated_shading_rate_map;
  import fsrm_pkg::*;

  localparam int TILE_PX         = 16;
  localparam int SCENE_MAX       = 16384;
  localparam int RANDOM_PHASES   = 10;
  localparam int TILES_PER_PHASE = 110;
  // The receiver holds off far longer than the five pipeline stages can
  // absorb, so in_ready must drop while the sender keeps offering tiles.
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int HOLD_OFF_TILES  = 40;
  // Comfortably more than the depth of the five-stage pipeline.
  localparam int SETTLE_CYCLES   = 10;
  localparam int CYCLE_LIMIT     = 500000;

  typedef enum int {
    DRAIN_FREE,
    DRAIN_RANDOM,
    DRAIN_THIRD,
    DRAIN_SLOW
  } drain_mode_e;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TARGET_W;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [TILE_IDX_W-1:0] tile_col  = '0;
  logic [TILE_IDX_W-1:0] tile_row  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RATE_W-1:0]     rate_code;

  int          mismatch_count;
  int          pending_rates;
  int unsigned cycle_count = 0;

  // Sender pacing and the scene size that random tiles are aimed at.
  bit gapless           = 1'b1;
  int burst_left        = 1;
  int hold_off_requests = 0;
  int aim_w             = 2048;
  int aim_h             = 2048;

  always #5 clk = ~clk;

  foveated_shading_rate_map #(
    .TILE      (TILE_PX),
    .MAX_SCENE (SCENE_MAX)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tile_col  (tile_col),
    .tile_row  (tile_row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rate_code (rate_code)
  );

  fsrm_rate_checker #(
    .TILE      (TILE_PX),
    .MAX_SCENE (SCENE_MAX)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .tile_col       (tile_col),
    .tile_row       (tile_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rate_code      (rate_code),
    .mismatch_count (mismatch_count),
    .pending_rates  (pending_rates)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_foveated_shading_rate_map: errors");
      $finish;
    end
  end

  // The receiver runs on its own: it switches between drain patterns in
  // segments of random length, and on request from the stimulus it holds
  // out_ready low for a long stretch that it counts itself.
  initial begin : drain_side
    drain_mode_e drain_mode;
    int          seg_left;
    int          hold_left;
    int          hold_seen;
    drain_mode = DRAIN_FREE;
    seg_left   = 0;
    hold_left  = 0;
    hold_seen  = 0;
    forever begin
      @(negedge clk);
      if (hold_off_requests != hold_seen) begin
        hold_seen = hold_off_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          drain_mode = drain_mode_e'($urandom_range(0, 3));
          seg_left   = $urandom_range(8, 160);
        end
        seg_left--;
        case (drain_mode)
          DRAIN_FREE:   out_ready <= 1'b1;
          DRAIN_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
          DRAIN_THIRD:  out_ready <= (seg_left % 3 == 0);
          default:      out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One register write; the aim of the random tiles follows the scene size.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_TARGET_W)
      aim_w = int'(value[SCENE_W-1:0]);
    if (idx == REG_TARGET_H)
      aim_h = int'(value[SCENE_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one tile and hold it until the transfer happens. valid stays high
  // when the next tile follows directly, so there is no glitch between tiles.
  task automatic send_tile(input logic [TILE_IDX_W-1:0] col,
                           input logic [TILE_IDX_W-1:0] row);
    @(negedge clk);
    in_valid <= 1'b1;
    tile_col <= col;
    tile_row <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Bursts of random length separated by random gaps, unless this phase
  // runs without gaps at all.
  task automatic pace();
    if (!gapless) begin
      burst_left--;
      if (burst_left <= 0) begin
        idle_cycles($urandom_range(1, 12));
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // Stop offering tiles and wait until every rate has come back, then let the
  // pipeline settle so that registers change only when idle.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rates != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Most tiles fall on the scene (plus up to two tiles beyond it) so that every ring
  // is hit; the rest cover the whole index range, far outside the image too.
  task automatic pick_tile(output logic [TILE_IDX_W-1:0] col,
                           output logic [TILE_IDX_W-1:0] row);
    int span_x;
    int span_y;
    span_x = (aim_w > SCENE_MAX ? SCENE_MAX : aim_w) / TILE_PX + 1;
    span_y = (aim_h > SCENE_MAX ? SCENE_MAX : aim_h) / TILE_PX + 1;
    if ($urandom_range(0, 3) == 0) begin
      col = TILE_IDX_W'($urandom_range(0, 2047));
      row = TILE_IDX_W'($urandom_range(0, 2047));
    end else begin
      col = TILE_IDX_W'($urandom_range(0, span_x));
      row = TILE_IDX_W'($urandom_range(0, span_y));
    end
  endtask

  // Scene sizes lean toward ordinary targets, with the empty, the one-pixel,
  // the largest supported and the oversized (saturating) scenes mixed in.
  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       pick_size = 32'd0;
      1:       pick_size = 32'd1;
      2:       pick_size = 32'(SCENE_MAX);
      3:       pick_size = 32'd32767;
      4:       pick_size = $urandom_range(0, 32767);
      default: pick_size = $urandom_range(256, 4096);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gaze();
    case ($urandom_range(0, 7))
      0:       pick_gaze = '0;
      1:       pick_gaze = '1;
      2:       pick_gaze = $urandom();
      default: pick_gaze = {16'($urandom_range(8192, 57343)),
                            16'($urandom_range(8192, 57343))};
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_radius(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0:       pick_radius = 32'd0;
      1:       pick_radius = 32'h0000_FFFF;
      2:       pick_radius = $urandom_range(0, 65535);
      default: pick_radius = $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_TARGET_W, pick_size());
    write_reg(REG_TARGET_H, pick_size());
    write_reg(REG_TWO_EYE, $urandom_range(0, 1));
    write_reg(REG_COARSEST_ALLOWED, $urandom_range(0, 1));
    write_reg(REG_GAZE_LEFT, pick_gaze());
    write_reg(REG_GAZE_RIGHT, pick_gaze());
    write_reg(REG_INNER_RADIUS, pick_radius(1000, 10000));
    write_reg(REG_OUTER_RADIUS, pick_radius(5000, 20000));
  endtask

  initial begin : stimulus
    logic [TILE_IDX_W-1:0] col;
    logic [TILE_IDX_W-1:0] row;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a 2048 square mono scene with the gaze in the middle.
    // Corner tiles, alternating bit patterns, the tiles around the centre
    // and tiles far outside the image.
    send_tile(11'd0, 11'd0);
    send_tile(11'd2047, 11'd2047);
    send_tile(11'd0, 11'd2047);
    send_tile(11'd2047, 11'd0);
    send_tile(11'd1365, 11'd682);
    send_tile(11'd682, 11'd1365);
    send_tile(11'd63, 11'd63);
    send_tile(11'd64, 11'd64);
    send_tile(11'd100, 11'd20);

    // Gaze placed exactly on the centre of tile (63,63) with both cutoffs at
    // zero: that tile sits right on the cutoff and keeps the finest rate,
    // while its neighbor falls in the outer ring at 4x4.
    quiesce();
    write_reg(REG_INNER_RADIUS, 32'd0);
    write_reg(REG_OUTER_RADIUS, 32'd0);
    write_reg(REG_GAZE_LEFT, 32'h7F00_7F00);
    write_reg(REG_COARSEST_ALLOWED, 32'd1);
    send_tile(11'd63, 11'd63);
    send_tile(11'd64, 11'd63);

    // Two eyes side by side with different gazes; tiles 127 and 128 sit on
    // either side of the eye boundary. The inner cutoff is set above the
    // outer one, so the middle ring can never appear on its own.
    quiesce();
    write_reg(REG_TARGET_W, 32'd4096);
    write_reg(REG_TWO_EYE, 32'd1);
    write_reg(REG_GAZE_LEFT, 32'h4000_8000);
    write_reg(REG_GAZE_RIGHT, 32'hC000_8000);
    write_reg(REG_INNER_RADIUS, 32'd20000);
    write_reg(REG_OUTER_RADIUS, 32'd9000);
    send_tile(11'd127, 11'd60);
    send_tile(11'd128, 11'd60);
    send_tile(11'd0, 11'd0);
    send_tile(11'd255, 11'd127);

    // Oversized scene that must saturate, gaze in the far corner and both
    // cutoffs at their maximum.
    quiesce();
    write_reg(REG_TARGET_W, 32'd32767);
    write_reg(REG_TARGET_H, 32'd32767);
    write_reg(REG_TWO_EYE, 32'd0);
    write_reg(REG_GAZE_LEFT, 32'hFFFF_FFFF);
    write_reg(REG_INNER_RADIUS, 32'h0000_FFFF);
    write_reg(REG_OUTER_RADIUS, 32'h0000_FFFF);
    send_tile(11'd1023, 11'd1023);
    send_tile(11'd2047, 11'd2047);
    send_tile(11'd0, 11'd0);

    // Zero-sized scene: the thresholds collapse, so nearly every tile lands
    // in the outer ring, which is 2x2 here.
    quiesce();
    write_reg(REG_TARGET_W, 32'd0);
    write_reg(REG_TARGET_H, 32'd0);
    write_reg(REG_GAZE_LEFT, 32'h0000_0000);
    write_reg(REG_INNER_RADIUS, 32'd0);
    write_reg(REG_OUTER_RADIUS, 32'd1);
    write_reg(REG_COARSEST_ALLOWED, 32'd0);
    send_tile(11'd0, 11'd0);
    send_tile(11'd5, 11'd5);
    send_tile(11'd2047, 11'd2047);

    // Random phases, each under fresh settings written while idle.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiesce();
      random_config();
      gapless    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < TILES_PER_PHASE; n++) begin
        if (p == 3 && n == 40) begin
          // Back-pressure: the receiver holds off while tiles keep coming
          // back to back, so the pipeline fills and in_ready falls.
          hold_off_requests++;
          for (int b = 0; b < HOLD_OFF_TILES; b++) begin
            pick_tile(col, row);
            send_tile(col, row);
          end
        end
        if (p % 3 == 1 && n == 70)
          quiesce();
        pick_tile(col, row);
        send_tile(col, row);
        pace();
      end
    end

    quiesce();
    if (mismatch_count == 0 && pending_rates == 0)
      $display("tb_foveated_shading_rate_map: clean");
    else
      $display("tb_foveated_shading_rate_map: errors");
    $finish;
  end

endmodule

>>> foveated_shading_rate_map.f
+incdir+hdl
hdl/fsrm_pkg.sv
hdl/fsrm_cfg.sv
hdl/fsrm_ctrl.sv
hdl/fsrm_dist.sv
hdl/fsrm_sq.sv
hdl/fsrm_rate.sv
hdl/foveated_shading_rate_map.sv
tb/sv/fsrm_rate_checker.sv
tb/sv/tb_foveated_shading_rate_map.sv
